// ===== design/dte_pkg.sv =====
// shared constants, character codes and controller/datapath interface types
package dte_pkg;

    localparam int MAG_W         = 64;
    localparam int DIG_W         = 4;
    localparam int BCD_DIGITS    = 20;
    localparam int BCD_W         = BCD_DIGITS * DIG_W;
    localparam int FLD_DIGITS    = 11;
    localparam int FLD_W         = FLD_DIGITS * DIG_W;
    localparam int FRAC_DIGITS   = 9;
    localparam int IDX_W         = 4;
    localparam int CNT_W         = 4;
    localparam int BITS_PER_STEP = 4;
    localparam int REM_W         = 6;
    localparam int BYTE_W        = 8;

    localparam logic [CNT_W-1:0] DABBLE_LAST = CNT_W'(MAG_W / BITS_PER_STEP - 1);
    localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(FLD_DIGITS - 1);

    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_H     = 8'h68;
    localparam logic [BYTE_W-1:0] CH_M     = 8'h6D;
    localparam logic [BYTE_W-1:0] CH_N     = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_S     = 8'h73;
    localparam logic [BYTE_W-1:0] CH_MU_HI = 8'hC2;
    localparam logic [BYTE_W-1:0] CH_MU_LO = 8'hB5;

    typedef enum logic [1:0] {
        UNIT_NS,
        UNIT_US,
        UNIT_MS,
        UNIT_SEC
    } unit_t;

    typedef enum logic [2:0] {
        FLD_NONE,
        FLD_HOURS,
        FLD_MIN,
        FLD_SEC,
        FLD_INT,
        FLD_FRAC
    } fld_sel_t;

    typedef struct packed {
        logic              load_in;
        logic              dabble;
        logic              div_load1;
        logic              div_step;
        logic              div_load2;
        fld_sel_t          fld_load;
        logic              emit;
        logic              emit_digit;
        logic [BYTE_W-1:0] lit;
        logic              last;
    } dte_cmd_t;

    typedef struct packed {
        logic  dabble_done;
        logic  div_done;
        logic  big;
        logic  zero;
        unit_t unit;
        logic  neg;
        logic  hours_nz;
        logic  min_nz;
        logic  frac_nz;
        logic  fld_last;
        logic  out_free;
    } dte_stat_t;

endpackage

// ===== design/dte_datapath.sv =====
// datapath: magnitude, binary to bcd, divide by sixty, digit fields, output register
module dte_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [dte_pkg::MAG_W-1:0]       s_tdata,
    input  dte_pkg::dte_cmd_t               cmd_i,
    output dte_pkg::dte_stat_t              stat_o,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dte_pkg::BYTE_W-1:0]      m_tdata,
    output logic                            m_tlast
);
    import dte_pkg::*;

    localparam int DIVV_W = 10;

    function automatic logic [IDX_W-1:0] msd_idx(input logic [FLD_W-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < FLD_DIGITS; i++) begin
            if (v[i*DIG_W +: DIG_W] != '0) r = IDX_W'(i);
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] lsd_idx(input logic [FLD_W-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = FLD_DIGITS - 1; i >= 0; i--) begin
            if (v[i*DIG_W +: DIG_W] != '0) r = IDX_W'(i);
        end
        return r;
    endfunction

    // value below sixty as two bcd digits, tens in the upper nibble
    function automatic logic [2*DIG_W-1:0] two_digits(input logic [REM_W-1:0] v);
        logic [DIG_W-1:0] t;
        logic [REM_W-1:0] o;
        t = '0;
        for (int k = 1; k < 6; k++) begin
            if (v >= REM_W'(k * 10)) t = DIG_W'(k);
        end
        o = v - REM_W'(t) * REM_W'(10);
        return {t, o[DIG_W-1:0]};
    endfunction

    logic [MAG_W-1:0]  bin_reg;
    logic [BCD_W-1:0]  bcd_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [FLD_W-1:0]  src_reg;
    logic [FLD_W-1:0]  quo_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  sec_reg;
    logic [FLD_W-1:0]  fld_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  stop_reg;
    logic              m_tvalid_reg;
    logic [BYTE_W-1:0] m_tdata_reg;
    logic              m_tlast_reg;

    logic [MAG_W-1:0]    in_mag;
    logic [BCD_W-1:0]    dab_bcd;
    logic [MAG_W-1:0]    dab_bin;
    logic [DIVV_W-1:0]   div_v;
    logic [DIG_W-1:0]    div_q;
    logic [DIVV_W-1:0]   div_r;
    logic [FLD_W-1:0]    low_digits;
    logic                big;
    unit_t               unit;
    logic                frac_nz;
    logic [IDX_W-1:0]    frac_top;
    logic [IDX_W-1:0]    int_stop;
    logic [2*DIG_W-1:0]  min_dig;
    logic [2*DIG_W-1:0]  sec_dig;
    logic [DIG_W-1:0]    cur_digit;
    logic                fld_last;
    logic                out_free;

    assign in_mag = s_tdata[MAG_W-1] ? (~s_tdata + MAG_W'(1)) : s_tdata;

    // four double-dabble steps per cycle
    always_comb begin
        dab_bcd = bcd_reg;
        dab_bin = bin_reg;
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            for (int d = 0; d < BCD_DIGITS; d++) begin
                if (dab_bcd[d*DIG_W +: DIG_W] >= 4'd5) begin
                    dab_bcd[d*DIG_W +: DIG_W] = dab_bcd[d*DIG_W +: DIG_W] + 4'd3;
                end
            end
            dab_bcd = {dab_bcd[BCD_W-2:0], dab_bin[MAG_W-1]};
            dab_bin = {dab_bin[MAG_W-2:0], 1'b0};
        end
    end

    // one decimal digit of long division by sixty
    always_comb begin
        div_v = (DIVV_W'(rem_reg) << 3) + (DIVV_W'(rem_reg) << 1)
              + DIVV_W'(src_reg[FLD_W-1 -: DIG_W]);
        div_q = '0;
        for (int k = 1; k < 10; k++) begin
            if (div_v >= DIVV_W'(k * 60)) div_q = DIG_W'(k);
        end
        div_r = div_v - DIVV_W'(div_q) * DIVV_W'(60);
    end

    assign low_digits = FLD_W'(bcd_reg[FRAC_DIGITS*DIG_W-1:0]);
    assign big        = |bcd_reg[BCD_W-1:FRAC_DIGITS*DIG_W];

    always_comb begin
        if (big) begin
            unit = UNIT_SEC;
        end else if (|bcd_reg[9*DIG_W-1:6*DIG_W]) begin
            unit = UNIT_MS;
        end else if (|bcd_reg[6*DIG_W-1:3*DIG_W]) begin
            unit = UNIT_US;
        end else begin
            unit = UNIT_NS;
        end
    end

    always_comb begin
        case (unit)
            UNIT_SEC: begin
                frac_nz  = |bcd_reg[9*DIG_W-1:0];
                frac_top = IDX_W'(8);
                int_stop = '0;
            end
            UNIT_MS: begin
                frac_nz  = |bcd_reg[6*DIG_W-1:0];
                frac_top = IDX_W'(5);
                int_stop = IDX_W'(6);
            end
            UNIT_US: begin
                frac_nz  = |bcd_reg[3*DIG_W-1:0];
                frac_top = IDX_W'(2);
                int_stop = IDX_W'(3);
            end
            default: begin
                frac_nz  = 1'b0;
                frac_top = '0;
                int_stop = '0;
            end
        endcase
    end

    assign min_dig   = two_digits(rem_reg);
    assign sec_dig   = two_digits(sec_reg);
    assign cur_digit = fld_reg[idx_reg*DIG_W +: DIG_W];
    assign fld_last  = (idx_reg == stop_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd_i.dabble || cmd_i.div_step) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end else if (cmd_i.load_in || cmd_i.div_load1 || cmd_i.div_load2) begin
            cnt_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load_in) begin
            bin_reg <= in_mag;
            bcd_reg <= '0;
            neg_reg <= s_tdata[MAG_W-1];
        end else if (cmd_i.dabble) begin
            bin_reg <= dab_bin;
            bcd_reg <= dab_bcd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.div_load1) begin
            src_reg <= bcd_reg[BCD_W-1:FRAC_DIGITS*DIG_W];
            rem_reg <= '0;
        end else if (cmd_i.div_load2) begin
            sec_reg <= rem_reg;
            src_reg <= quo_reg;
            rem_reg <= '0;
        end else if (cmd_i.div_step) begin
            src_reg <= {src_reg[FLD_W-DIG_W-1:0], {DIG_W{1'b0}}};
            quo_reg <= {quo_reg[FLD_W-DIG_W-1:0], div_q};
            rem_reg <= div_r[REM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd_i.fld_load)
            FLD_HOURS: begin
                fld_reg  <= quo_reg;
                idx_reg  <= msd_idx(quo_reg);
                stop_reg <= '0;
            end
            FLD_MIN: begin
                fld_reg  <= FLD_W'(min_dig);
                idx_reg  <= (min_dig[2*DIG_W-1:DIG_W] != '0) ? IDX_W'(1) : '0;
                stop_reg <= '0;
            end
            FLD_SEC: begin
                fld_reg  <= FLD_W'(sec_dig);
                idx_reg  <= (sec_dig[2*DIG_W-1:DIG_W] != '0) ? IDX_W'(1) : '0;
                stop_reg <= '0;
            end
            FLD_INT: begin
                fld_reg  <= low_digits;
                idx_reg  <= msd_idx(low_digits);
                stop_reg <= int_stop;
            end
            FLD_FRAC: begin
                fld_reg  <= low_digits;
                idx_reg  <= frac_top;
                stop_reg <= lsd_idx(low_digits);
            end
            default: begin
                if (cmd_i.emit && cmd_i.emit_digit && !fld_last) begin
                    idx_reg <= idx_reg - IDX_W'(1);
                end
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd_i.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.emit) begin
            m_tdata_reg <= cmd_i.emit_digit ? (CH_ZERO + BYTE_W'(cur_digit)) : cmd_i.lit;
            m_tlast_reg <= cmd_i.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign stat_o.dabble_done = (cnt_reg == DABBLE_LAST);
    assign stat_o.div_done    = (cnt_reg == DIV_LAST);
    assign stat_o.big         = big;
    assign stat_o.zero        = (bcd_reg == '0);
    assign stat_o.unit        = unit;
    assign stat_o.neg         = neg_reg;
    assign stat_o.hours_nz    = |quo_reg;
    assign stat_o.min_nz      = (|quo_reg) || (rem_reg != '0);
    assign stat_o.frac_nz     = frac_nz;
    assign stat_o.fld_last    = fld_last;
    assign stat_o.out_free    = out_free;

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.emit |-> (!m_tvalid_reg || m_tready))
        else $error("beat loaded over an untaken beat");

    a_digit_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_i.emit && cmd_i.emit_digit) |-> (cur_digit <= 4'd9))
        else $error("emitted digit is not decimal");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_i.emit && cmd_i.emit_digit) |-> (idx_reg >= stop_reg))
        else $error("digit index ran past field end");

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.div_step |=> (rem_reg < REM_W'(60)))
        else $error("divide by sixty remainder out of range");

endmodule

// ===== design/dte_ctrl.sv =====
// controller: sequences conversion, division and byte emission
module dte_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  dte_pkg::dte_stat_t  stat_i,
    output dte_pkg::dte_cmd_t   cmd_o
);
    import dte_pkg::*;

    typedef enum logic [22:0] {
        ST_IDLE     = 23'h000001,
        ST_DABBLE   = 23'h000002,
        ST_CLASSIFY = 23'h000004,
        ST_DIV1     = 23'h000008,
        ST_DIV2_LD  = 23'h000010,
        ST_DIV2     = 23'h000020,
        ST_SIGN     = 23'h000040,
        ST_LD_HOURS = 23'h000080,
        ST_EM_HOURS = 23'h000100,
        ST_EM_H     = 23'h000200,
        ST_LD_MIN   = 23'h000400,
        ST_EM_MIN   = 23'h000800,
        ST_EM_M     = 23'h001000,
        ST_LD_SEC   = 23'h002000,
        ST_EM_SEC   = 23'h004000,
        ST_LD_INT   = 23'h008000,
        ST_EM_INT   = 23'h010000,
        ST_LD_FRAC  = 23'h020000,
        ST_EM_DOT   = 23'h040000,
        ST_EM_FRAC  = 23'h080000,
        ST_UNIT     = 23'h100000,
        ST_EM_MU    = 23'h200000,
        ST_EM_S     = 23'h400000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t after_sign;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        if (!stat_i.big) begin
            after_sign = ST_LD_INT;
        end else if (stat_i.hours_nz) begin
            after_sign = ST_LD_HOURS;
        end else if (stat_i.min_nz) begin
            after_sign = ST_LD_MIN;
        end else begin
            after_sign = ST_LD_SEC;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_o.load_in = 1'b1;
                    state_next    = ST_DABBLE;
                end
            end
            ST_DABBLE: begin
                cmd_o.dabble = 1'b1;
                if (stat_i.dabble_done) state_next = ST_CLASSIFY;
            end
            ST_CLASSIFY: begin
                cmd_o.div_load1 = 1'b1;
                state_next      = stat_i.big ? ST_DIV1 : ST_SIGN;
            end
            ST_DIV1: begin
                cmd_o.div_step = 1'b1;
                if (stat_i.div_done) state_next = ST_DIV2_LD;
            end
            ST_DIV2_LD: begin
                cmd_o.div_load2 = 1'b1;
                state_next      = ST_DIV2;
            end
            ST_DIV2: begin
                cmd_o.div_step = 1'b1;
                if (stat_i.div_done) state_next = ST_SIGN;
            end
            ST_SIGN: begin
                if (!stat_i.neg) begin
                    state_next = after_sign;
                end else if (stat_i.out_free) begin
                    cmd_o.emit = 1'b1;
                    cmd_o.lit  = CH_MINUS;
                    state_next = after_sign;
                end
            end
            ST_LD_HOURS: begin
                cmd_o.fld_load = FLD_HOURS;
                state_next     = ST_EM_HOURS;
            end
            ST_EM_HOURS: begin
                if (stat_i.out_free) begin
                    cmd_o.emit       = 1'b1;
                    cmd_o.emit_digit = 1'b1;
                    if (stat_i.fld_last) state_next = ST_EM_H;
                end
            end
            ST_EM_H: begin
                if (stat_i.out_free) begin
                    cmd_o.emit = 1'b1;
                    cmd_o.lit  = CH_H;
                    state_next = ST_LD_MIN;
                end
            end
            ST_LD_MIN: begin
                cmd_o.fld_load = FLD_MIN;
                state_next     = ST_EM_MIN;
            end
            ST_EM_MIN: begin
                if (stat_i.out_free) begin
                    cmd_o.emit       = 1'b1;
                    cmd_o.emit_digit = 1'b1;
                    if (stat_i.fld_last) state_next = ST_EM_M;
                end
            end
            ST_EM_M: begin
                if (stat_i.out_free) begin
                    cmd_o.emit = 1'b1;
                    cmd_o.lit  = CH_M;
                    state_next = ST_LD_SEC;
                end
            end
            ST_LD_SEC: begin
                cmd_o.fld_load = FLD_SEC;
                state_next     = ST_EM_SEC;
            end
            ST_EM_SEC: begin
                if (stat_i.out_free) begin
                    cmd_o.emit       = 1'b1;
                    cmd_o.emit_digit = 1'b1;
                    if (stat_i.fld_last) state_next = ST_LD_FRAC;
                end
            end
            ST_LD_INT: begin
                cmd_o.fld_load = FLD_INT;
                state_next     = ST_EM_INT;
            end
            ST_EM_INT: begin
                if (stat_i.out_free) begin
                    cmd_o.emit       = 1'b1;
                    cmd_o.emit_digit = 1'b1;
                    if (stat_i.fld_last) state_next = ST_LD_FRAC;
                end
            end
            ST_LD_FRAC: begin
                cmd_o.fld_load = FLD_FRAC;
                state_next     = stat_i.frac_nz ? ST_EM_DOT : ST_UNIT;
            end
            ST_EM_DOT: begin
                if (stat_i.out_free) begin
                    cmd_o.emit = 1'b1;
                    cmd_o.lit  = CH_DOT;
                    state_next = ST_EM_FRAC;
                end
            end
            ST_EM_FRAC: begin
                if (stat_i.out_free) begin
                    cmd_o.emit       = 1'b1;
                    cmd_o.emit_digit = 1'b1;
                    if (stat_i.fld_last) state_next = ST_UNIT;
                end
            end
            ST_UNIT: begin
                // zero and durations in the seconds unit go straight to the closing s
                if (stat_i.zero || stat_i.unit == UNIT_SEC) begin
                    state_next = ST_EM_S;
                end else if (stat_i.out_free) begin
                    cmd_o.emit = 1'b1;
                    case (stat_i.unit)
                        UNIT_US: begin
                            cmd_o.lit  = CH_MU_HI;
                            state_next = ST_EM_MU;
                        end
                        UNIT_MS: begin
                            cmd_o.lit  = CH_M;
                            state_next = ST_EM_S;
                        end
                        default: begin
                            cmd_o.lit  = CH_N;
                            state_next = ST_EM_S;
                        end
                    endcase
                end
            end
            ST_EM_MU: begin
                if (stat_i.out_free) begin
                    cmd_o.emit = 1'b1;
                    cmd_o.lit  = CH_MU_LO;
                    state_next = ST_EM_S;
                end
            end
            ST_EM_S: begin
                if (stat_i.out_free) begin
                    cmd_o.emit = 1'b1;
                    cmd_o.lit  = CH_S;
                    cmd_o.last = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/duration_to_text_encoder.sv =====
// top level: nanosecond duration to text byte stream encoder
// conversion: the 64-bit binary to bcd converter (4 bits a cycle) and, for durations of a
//   second or more, two 11-digit divide by sixty passes (one digit a cycle) set the
//   conversion time, then one byte a cycle while the output is not stalled; a new
//   duration is accepted only after the last byte of the previous one is loaded
// reset: aresetn low clears the controller and the output valid; no clearing pass
module duration_to_text_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] duration, signed ns
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] text_byte
    output logic        m_tlast    // last_byte
);
    import dte_pkg::*;

    // command and status between sequencer and datapath
    dte_cmd_t  cmd;
    dte_stat_t stat;

    // sequencer: one duration at a time, paced by the output register
    dte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat_i   (stat),
        .cmd_o    (cmd)
    );

    // datapath: magnitude, bcd conversion, h/m/s split, digit fields and the
    // output register that lets a new duration start while the final beat waits
    dte_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd_i    (cmd),
        .stat_o   (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== verif/tb_duration_to_text_encoder.sv =====
// testbench for the duration to text encoder: directed table, random durations, byte checker
module tb_duration_to_text_encoder;

    localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
    localparam logic [63:0] NS_PER_MS  = 64'd1000000;
    localparam logic [63:0] NS_PER_US  = 64'd1000;
    localparam logic [63:0] SIXTY      = 64'd60;
    localparam int DIRECTED_ROWS = 24;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } text_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = 64'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    text_beat_t expected_text[$];
    logic [7:0] text_build[$];
    int         fail_count = 0;
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;

    // idle percentages per phase: none, sender, receiver, both
    int phase_src_idle[4]   = '{0, 82, 0, 12};
    int phase_sink_stall[4] = '{0, 0, 82, 12};

    // directed rows; an empty string means the row is checked by the predictor
    logic [63:0] dir_duration[DIRECTED_ROWS] = '{
        64'd0,
        64'h8000_0000_0000_0000,
        64'h7FFF_FFFF_FFFF_FFFF,
        64'd1,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'd999,
        64'd1000,
        64'd1001,
        64'd999999,
        64'd1000000,
        64'd999999999,
        64'd1000000000,
        64'd1500000000,
        64'd59999999999,
        64'd60000000000,
        64'd3599999999999,
        64'd3600000000000,
        64'd3661001000000,
        -64'd3600000000000,
        -64'd1234567,
        64'd12345678901234,
        64'h8000_0000_0000_0001,
        64'd123456,
        -64'd999999999
    };
    string dir_text[DIRECTED_ROWS] = '{
        "0s",
        "-2562047h47m16.854775808s",
        "2562047h47m16.854775807s",
        "1ns",
        "-1ns",
        "999ns",
        "1\302\265s",
        "1.001\302\265s",
        "999.999\302\265s",
        "1ms",
        "999.999999ms",
        "1s",
        "1.5s",
        "59.999999999s",
        "1m0s",
        "59m59.999999999s",
        "1h0m0s",
        "1h1m1.001s",
        "-1h0m0s",
        "",
        "",
        "",
        "",
        ""
    };

    duration_to_text_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // generous hard stop, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("FAIL duration_to_text_encoder");
        $finish;
    end

    // fraction digits of v / 10^prec, trailing zeros and point dropped
    function automatic logic [63:0] prepend_fraction(input logic [63:0] v, input int prec);
        logic       seen;
        logic [3:0] dig;
        seen = 1'b0;
        for (int i = 0; i < prec; i++) begin
            dig = 4'(v % 64'd10);
            if (dig != 4'd0)
                seen = 1'b1;
            if (seen)
                text_build.push_front(8'h30 + 8'(dig));
            v = v / 64'd10;
        end
        if (seen)
            text_build.push_front(".");
        return v;
    endfunction

    function automatic void prepend_integer(input logic [63:0] v);
        do begin
            text_build.push_front(8'h30 + 8'(v % 64'd10));
            v = v / 64'd10;
        end while (v != 64'd0);
    endfunction

    // builds the text of one duration and queues its beats
    function automatic void predict_duration_text(input logic [63:0] raw);
        logic        neg;
        logic [63:0] mag;
        int          prec;
        text_build.delete();
        neg = raw[63];
        mag = neg ? (64'd0 - raw) : raw;
        if (mag == 64'd0) begin
            text_build.push_back("0");
            text_build.push_back("s");
        end else begin
            text_build.push_front("s");
            if (mag < NS_PER_SEC) begin
                if (mag < NS_PER_US) begin
                    prec = 0;
                    text_build.push_front("n");
                end else if (mag < NS_PER_MS) begin
                    // micro sign, utf-8
                    prec = 3;
                    text_build.push_front(8'hB5);
                    text_build.push_front(8'hC2);
                end else begin
                    prec = 6;
                    text_build.push_front("m");
                end
                mag = prepend_fraction(mag, prec);
                prepend_integer(mag);
            end else begin
                mag = prepend_fraction(mag, 9);
                prepend_integer(mag % SIXTY);
                mag = mag / SIXTY;
                if (mag != 64'd0) begin
                    text_build.push_front("m");
                    prepend_integer(mag % SIXTY);
                    mag = mag / SIXTY;
                    if (mag != 64'd0) begin
                        text_build.push_front("h");
                        prepend_integer(mag);
                    end
                end
            end
            if (neg)
                text_build.push_front("-");
        end
        for (int k = 0; k < text_build.size(); k++)
            expected_text.push_back('{text_build[k], k == text_build.size() - 1});
    endfunction

    function automatic logic [63:0] pow10(input int e);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < e; i++)
            p = p * 64'd10;
        return p;
    endfunction

    // random duration spread over every unit and field size
    function automatic logic [63:0] rand_duration();
        logic [63:0] mag;
        logic [63:0] rnd;
        logic [63:0] step;
        rnd = {$urandom, $urandom};
        case ($urandom_range(7))
            0: mag = 64'($urandom_range(999));
            1: mag = 64'($urandom_range(999999));
            2: mag = 64'($urandom_range(999999999));
            3: mag = rnd % 64'd60000000000;
            4: mag = rnd % 64'd3600000000000;
            5: mag = rnd >> $urandom_range(63);
            6: return rnd;
            default: mag = 64'($urandom_range(120)) * pow10($urandom_range(12));
        endcase
        // force trailing zeros now and then
        if ($urandom_range(3) == 0) begin
            step = pow10($urandom_range(9));
            mag = mag - mag % step;
        end
        return $urandom_range(1) ? (64'd0 - mag) : mag;
    endfunction

    // one input beat; typed text is used when given, else the predictor
    task automatic send_duration(input logic [63:0] d, input string typed);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        if (typed.len() == 0) begin
            predict_duration_text(d);
        end else begin
            for (int k = 0; k < typed.len(); k++)
                expected_text.push_back('{typed[k], k == typed.len() - 1});
        end
    endtask

    // receiver back pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_text.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got byte %h last %b",
                         $time, m_tdata, m_tlast);
                fail_count <= fail_count + 1;
            end else begin
                if (m_tdata !== expected_text[0].text_byte ||
                    m_tlast !== expected_text[0].last_byte) begin
                    $display("%0t: mismatch, expected byte %h last %b, got byte %h last %b",
                             $time, expected_text[0].text_byte, expected_text[0].last_byte,
                             m_tdata, m_tlast);
                    fail_count <= fail_count + 1;
                end
                void'(expected_text.pop_front());
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part with no idling
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_duration(dir_duration[r], dir_text[r]);

        for (int p = 0; p < 4; p++) begin
            src_idle_pct = phase_src_idle[p];
            sink_stall_pct <= phase_sink_stall[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_duration(rand_duration(), "");
        end
        s_tvalid <= 1'b0;

        while (expected_text.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && expected_text.size() == 0) begin
            $display("PASS duration_to_text_encoder");
        end else begin
            $display("FAIL duration_to_text_encoder");
        end
        $finish;
    end

endmodule
